/* hw/rtl/zlrd_pkg.sv */
// Shared types and constants for the zero-length run decoder.
// Result record, register indexes and field widths; no dependencies.
package zlrd_pkg;

    localparam int LEN_W  = 25;
    localparam int BYTE_W = 8;
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] CFG_OUTPUT_LENGTH = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_RUN_THRESHOLD = 2'd1;

    localparam logic [LEN_W-1:0]  LENGTH_RESET    = 25'd131072;
    localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 8'd64;

    typedef struct packed {
        logic [BYTE_W-1:0] out_value;
        logic [BYTE_W-1:0] repeat_count;
        logic              block_done;
        logic              decode_error;
    } t_result;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

endpackage

/* hw/rtl/zlrd_front.sv */
// Front end: takes source bytes, tracks header/literal state and block fill,
// and pushes one result record per byte that yields one. Uses zlrd_pkg.
module zlrd_front import zlrd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_cfg_write,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]  i_cfg_data,
    output logic              o_push,
    output t_result           o_result
);

    typedef enum logic {
        MODE_HEADER,
        MODE_LITERAL
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [BYTE_W-1:0] r_left, n_left;
    logic [LEN_W-1:0]  r_written, n_written;
    logic              r_error, n_error;
    logic [LEN_W-1:0]  r_out_len;
    logic [BYTE_W-1:0] r_thresh;

    logic [BYTE_W-1:0] thresh;
    logic [BYTE_W:0]   run_len;
    logic [BYTE_W:0]   zeros;
    logic [LEN_W:0]    lit_end;
    logic [LEN_W:0]    zero_end;
    logic              full;
    logic              emit;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] repeats;

    always_comb begin
        thresh   = (r_thresh == '0) ? BYTE_W'(1) : r_thresh;
        run_len  = {1'b0, i_data_byte} + (BYTE_W+1)'(1);
        zeros    = run_len - {1'b0, thresh};
        lit_end  = {1'b0, r_written} + {{(LEN_W-BYTE_W){1'b0}}, run_len};
        zero_end = {1'b0, r_written} + {{(LEN_W-BYTE_W){1'b0}}, zeros};
        full     = r_written >= r_out_len;

        n_mode    = r_mode;
        n_left    = r_left;
        n_written = r_written;
        n_error   = r_error;
        emit      = 1'b0;
        value     = '0;
        repeats   = '0;

        if (r_error) begin
            // swallow
        end else if (r_mode == MODE_LITERAL) begin
            emit      = 1'b1;
            value     = i_data_byte;
            repeats   = BYTE_W'(1);
            n_written = r_written + LEN_W'(1);
            n_left    = (r_left != '0) ? r_left - BYTE_W'(1) : r_left;
            if (n_left == '0) begin
                n_mode = MODE_HEADER;
            end
        end else if (!full) begin
            if (run_len <= {1'b0, thresh}) begin
                if (lit_end > {1'b0, r_out_len}) begin
                    n_error = 1'b1;
                end else begin
                    n_mode = MODE_LITERAL;
                    n_left = run_len[BYTE_W-1:0];
                end
            end else begin
                if (zero_end > {1'b0, r_out_len}) begin
                    n_error = 1'b1;
                end else begin
                    emit      = 1'b1;
                    repeats   = zeros[BYTE_W-1:0];
                    n_written = zero_end[LEN_W-1:0];
                end
            end
        end

        o_result.out_value    = value;
        o_result.repeat_count = repeats;
        o_result.block_done   = i_last_byte;
        o_result.decode_error = i_last_byte &
            (n_error | (n_mode == MODE_LITERAL) | (n_written != r_out_len));
        o_push = i_accept & (emit | i_last_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_HEADER;
            r_left    <= '0;
            r_written <= '0;
            r_error   <= 1'b0;
            r_out_len <= LENGTH_RESET;
            r_thresh  <= THRESHOLD_RESET;
        end else begin
            if (i_accept) begin
                if (i_last_byte) begin
                    r_mode    <= MODE_HEADER;
                    r_left    <= '0;
                    r_written <= '0;
                    r_error   <= 1'b0;
                end else begin
                    r_mode    <= n_mode;
                    r_left    <= n_left;
                    r_written <= n_written;
                    r_error   <= n_error;
                end
            end
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_OUTPUT_LENGTH: r_out_len <= i_cfg_data;
                    CFG_RUN_THRESHOLD: r_thresh  <= i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* hw/rtl/zlrd_queue.sv */
// Result queue between front end and output port: small flop FIFO whose
// head drives the output channel. Uses zlrd_pkg for the result record.
module zlrd_queue import zlrd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_push_data,
    input  logic          i_pop,
    output t_result       o_head,
    output t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    always_comb begin
        o_status.full      = r_count == CNT_W'(DEPTH);
        o_status.not_empty = r_count != '0;
        do_push            = i_push & ~o_status.full;
        do_pop             = i_pop & o_status.not_empty;
        o_head             = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/zero_length_run_decoder_unit.sv */
// Top level of the zero-length run decoder: front end plus result queue.
// Uses zlrd_pkg, zlrd_front and zlrd_queue.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | sink      | i_in_valid / o_in_stall  | i_data_byte, i_last_byte
//   out     | source    | o_out_valid / i_out_stall| o_out_value, o_repeat_count,
//           |           |                         | o_block_done, o_decode_error
//   cfg     | sink      | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One source byte per cycle while o_in_stall is low; its result, if any, is registered in the result queue.
// The rate is set by the combinational header decode and the registered fill-count update.
// o_in_stall rises only when the QUEUE_DEPTH-entry result queue is full.
// Synchronous active-low reset; config registers return to their defaults.
module zero_length_run_decoder_unit import zlrd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_value,
    output logic [BYTE_W-1:0] o_repeat_count,
    output logic              o_block_done,
    output logic              o_decode_error,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]  i_cfg_data
);

    t_result       push_data;
    t_result       head;
    t_queue_status q_status;
    logic          push;
    logic          accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_status.full;
    assign accept      = i_in_valid & ~q_status.full;
    assign o_out_valid = q_status.not_empty;

    assign o_out_value    = head.out_value;
    assign o_repeat_count = head.repeat_count;
    assign o_block_done   = head.block_done;
    assign o_decode_error = head.decode_error;

    zlrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_write (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_result    (push_data)
    );

    zlrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (o_out_valid & ~i_out_stall),
        .o_head      (head),
        .o_status    (q_status)
    );

`ifndef SYNTHESIS
    a_data_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_block_done |-> o_repeat_count != '0)
        else $error("data result without repeat count");

    a_error_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_decode_error |-> o_block_done)
        else $error("error flag outside done result");

    a_literal_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_value != '0 |-> o_repeat_count == BYTE_W'(1))
        else $error("nonzero value with repeat count other than one");
`endif

endmodule

/* dv/zlrd_checker.sv */
// Checker for the zero-length run decoder: watches the source, result and register channels.
// Predicts each result from accepted source bytes and compares it with what the block returns.
// Depends on zlrd_pkg for the result record, register indexes and field widths.
module zlrd_checker import zlrd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] i_out_value,
    input  logic [BYTE_W-1:0] i_repeat_count,
    input  logic              i_block_done,
    input  logic              i_decode_error,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]  i_cfg_data,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_results,
    output int                o_blocks,
    output int                o_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        EXPECT_HEADER = 2'd0,
        IN_LITERALS   = 2'd1
    } t_mode;

    t_mode             mode;
    logic [8:0]        lits_left;
    logic [LEN_W-1:0]  bytes_out;
    logic              err_latched;
    logic [LEN_W-1:0]  out_len;
    logic [BYTE_W-1:0] thresh;

    t_result expected_results[$];
    int      mismatches = 0;
    int      results = 0;
    int      blocks = 0;
    int      flagged = 0;

    task automatic restart_block_state();
        mode        = EXPECT_HEADER;
        lits_left   = '0;
        bytes_out   = '0;
        err_latched = 1'b0;
    endtask

    task automatic decode_source_byte(input logic [BYTE_W-1:0] b, input logic last,
                                      output logic produced, output t_result res);
        logic              emit;
        logic [BYTE_W-1:0] val;
        int unsigned       rep;
        int unsigned       room;
        int unsigned       len;
        int unsigned       n;
        int unsigned       z;
        logic              full;
        emit = 1'b0;
        val  = '0;
        rep  = 0;
        full = bytes_out >= out_len;
        room = full ? 0 : 32'(out_len) - 32'(bytes_out);
        if (err_latched) begin
            // everything swallowed until the last byte
        end else if (mode == IN_LITERALS) begin
            emit      = 1'b1;
            val       = b;
            rep       = 1;
            bytes_out = bytes_out + 1'b1;
            if (lits_left > 0) lits_left = lits_left - 1'b1;
            if (lits_left == 0) mode = EXPECT_HEADER;
        end else if (!full) begin
            len = 32'(b) + 1;
            n   = (thresh == 0) ? 1 : 32'(thresh);
            if (len <= n) begin
                if (len > room) begin
                    err_latched = 1'b1;
                end else begin
                    mode      = IN_LITERALS;
                    lits_left = len[8:0];
                end
            end else begin
                z = len - n;
                if (z > room) begin
                    err_latched = 1'b1;
                end else begin
                    emit      = 1'b1;
                    rep       = z;
                    bytes_out = bytes_out + z[LEN_W-1:0];
                end
            end
        end
        res      = '0;
        produced = 1'b0;
        if (last) begin
            res.out_value    = emit ? val : '0;
            res.repeat_count = emit ? rep[BYTE_W-1:0] : '0;
            res.block_done   = 1'b1;
            res.decode_error = err_latched || mode == IN_LITERALS || bytes_out != out_len;
            produced         = 1'b1;
            restart_block_state();
        end else if (emit) begin
            res.out_value    = val;
            res.repeat_count = rep[BYTE_W-1:0];
            produced         = 1'b1;
        end
    endtask

    task automatic flag_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        results++;
        if (got.block_done) begin
            blocks++;
            if (got.decode_error) flagged++;
        end
        if (expected_results.size() == 0) begin
            $display({"%0t: unexpected result: expected none, ",
                      "actual value %0d count %0d done %0b err %0b"},
                     $time, got.out_value, got.repeat_count, got.block_done,
                     got.decode_error);
            mismatches++;
        end else begin
            want = expected_results.pop_front();
            flag_field("out_value", want.out_value, got.out_value);
            flag_field("repeat_count", want.repeat_count, got.repeat_count);
            flag_field("block_done", want.block_done, got.block_done);
            flag_field("decode_error", want.decode_error, got.decode_error);
        end
    endtask

    always @(posedge i_clk) begin
        logic    produced;
        t_result res;
        if (!i_rst_n) begin
            out_len = LENGTH_RESET;
            thresh  = THRESHOLD_RESET;
            restart_block_state();
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OUTPUT_LENGTH: out_len = i_cfg_data;
                    CFG_RUN_THRESHOLD: thresh = i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                decode_source_byte(i_data_byte, i_last_byte, produced, res);
                if (produced) expected_results.push_back(res);
            end
            if (i_out_valid && !i_out_stall) begin
                res.out_value    = i_out_value;
                res.repeat_count = i_repeat_count;
                res.block_done   = i_block_done;
                res.decode_error = i_decode_error;
                check_result(res);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_results.size();
        o_results    <= results;
        o_blocks     <= blocks;
        o_flagged    <= flagged;
    end

endmodule

/* dv/testbench.sv */
// Top of the zero-length run decoder testbench: clock, reset, stimulus and verdict.
// Drives directed and random compressed blocks under several register settings.
// Depends on zlrd_pkg, zero_length_run_decoder_unit and zlrd_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import zlrd_pkg::*;

    typedef logic [BYTE_W-1:0] t_bytes[$];

    localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_BYTES   = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_TARGET    = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_last_byte = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [BYTE_W-1:0] o_out_value;
    logic [BYTE_W-1:0] o_repeat_count;
    logic              o_block_done;
    logic              o_decode_error;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [LEN_W-1:0]  i_cfg_data = '0;

    int mismatches;
    int pending;
    int results;
    int blocks;
    int flagged;
    int bytes_sent = 0;
    int settings = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    zero_length_run_decoder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_value    (o_out_value),
        .o_repeat_count (o_repeat_count),
        .o_block_done   (o_block_done),
        .o_decode_error (o_decode_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    zlrd_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_value    (o_out_value),
        .i_repeat_count (o_repeat_count),
        .i_block_done   (o_block_done),
        .i_decode_error (o_decode_error),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results      (results),
        .o_blocks       (blocks),
        .o_flagged      (flagged)
    );

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // well-formed encoding of target output bytes with effective threshold n
    function automatic t_bytes encode_block(input int unsigned target, input int unsigned n);
        t_bytes      q;
        int unsigned left;
        int unsigned zmax;
        int unsigned z;
        int unsigned lits;
        left = target;
        while (left > 0) begin
            zmax = 256 - n;
            if (zmax > left) zmax = left;
            if ($urandom_range(0, 2) == 0) begin
                z = $urandom_range(1, zmax);
                q.push_back(BYTE_W'(n + z - 1));
                left -= z;
            end else begin
                lits = $urandom_range(1, (n < left) ? n : left);
                q.push_back(BYTE_W'(lits - 1));
                repeat (lits) q.push_back(BYTE_W'($urandom));
                left -= lits;
            end
        end
        if (q.size() == 0) q.push_back(BYTE_W'($urandom));
        return q;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = no_gaps ? 0 : idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic send_stream(input t_bytes q);
        for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
    endtask

    // idle the source and let every outstanding request come back
    task automatic drain();
        i_in_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] thr,
                             input bit spare);
        drain();
        write_reg(CFG_OUTPUT_LENGTH, len);
        write_reg(CFG_RUN_THRESHOLD, thr);
        if (spare) write_reg(CFG_SPARE, LEN_W'($urandom));
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic random_block(input logic [LEN_W-1:0] out_len, input int unsigned n);
        t_bytes      q;
        int unsigned target;
        int          r;
        int          cut;
        target = (out_len > MAX_TARGET) ? $urandom_range(1, MAX_TARGET) : 32'(out_len);
        q = encode_block(target, n);
        r = $urandom_range(0, 99);
        if (r >= 70 && r < 80 && q.size() > 1) begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut) void'(q.pop_back());
        end else if (r >= 80 && r < 88) begin
            repeat ($urandom_range(1, 4)) q.push_back(BYTE_W'($urandom));
        end else if (r >= 88) begin
            q.delete();
            repeat ($urandom_range(1, 10)) q.push_back(BYTE_W'($urandom));
        end
        send_stream(q);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        bit stall_on;
        int span;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                stall_on = ($urandom_range(0, 2) == 0);
                span = stall_on ? idle_cycles() : $urandom_range(1, 40);
                if (span == 0) span = 1;
                i_out_stall <= stall_on;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int               start;
        int               r;
        logic [LEN_W-1:0] len_v;
        logic [7:0]       thr8;
        logic [LEN_W-1:0] thr_v;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small block: literals, zero run, full block swallowing, clean close
        configure(25'd6, 25'd4, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h06, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h37, 1'b0);
        send_byte(8'h00, 1'b1);
        // zero run past the end of the block, then swallowed bytes
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        // last byte inside a literal run
        send_byte(8'h03, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        // last byte right on a literal header
        send_byte(8'h02, 1'b1);
        // literal run past the end of the block
        send_byte(8'h08, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b1);

        // zero threshold acts as one: longest zero run, last byte carrying data
        configure(25'd256, 25'd0, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFE, 1'b0);

        // block length lowered below what is already written
        configure(25'd10, 25'd255, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            r = $urandom_range(0, 99);
            if (r < 8) len_v = '0;
            else if (r < 14) len_v = 25'd16777216;
            else if (r < 18) len_v = '1;
            else if (r < 22) len_v = LEN_W'($urandom);
            else if (r < 40) len_v = LEN_W'($urandom_range(60, MAX_TARGET));
            else len_v = LEN_W'($urandom_range(1, 60));
            r = $urandom_range(0, 99);
            if (r < 10) thr8 = 8'd0;
            else if (r < 20) thr8 = 8'd1;
            else if (r < 30) thr8 = 8'd255;
            else thr8 = 8'($urandom_range(1, 255));
            if (p == 0) begin
                len_v = '0;
                thr8  = 8'd1;
            end else if (p == 1) begin
                len_v = 25'd16777216;
                thr8  = 8'd255;
            end else if (p == 2) begin
                len_v = LEN_W'($urandom_range(100, MAX_TARGET));
                thr8  = 8'($urandom_range(2, 20));
            end
            thr_v = {($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'd0, thr8};
            configure(len_v, thr_v, $urandom_range(0, 3) == 0);
            no_gaps = (p % 3 == 2);
            if (p == 2) hold_req = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                random_block(len_v, (thr8 == 0) ? 1 : thr8);
        end

        no_gaps = 1'b0;
        drain();
        $display("Sent %0d source bytes under %0d register settings,",
                 bytes_sent, settings);
        $display("with a %0d-cycle output hold; checked %0d results.",
                 HOLD_CYCLES, results);
        $display("%0d blocks closed, %0d of them flagged malformed.", blocks, flagged);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/zlrd_pkg.sv
hw/rtl/zlrd_front.sv
hw/rtl/zlrd_queue.sv
hw/rtl/zero_length_run_decoder_unit.sv
dv/zlrd_checker.sv
dv/testbench.sv
